>>> sv/best_fit_block_allocator_top_macros.svh
// assertion macros shared by the allocator checker
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst is high
`define BFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst is high
`define BFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bfba_pkg.sv
// shared constants, header layout and shared-adder types for the allocator
package bfba_pkg;

  localparam int HEAP_GRANULES = 4096;
  localparam int GRANULE_BYTES = 16;
  localparam int HEADER_BYTES  = 8;

  localparam int REQ_W      = 16;
  localparam int OUT_W      = 16;
  localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);

  // header index reaches HEAP_GRANULES itself (end mark slot)
  localparam int IDX_W      = $clog2(HEAP_GRANULES + 1);
  localparam int SIZE_W     = IDX_W;
  localparam int WORD_W     = SIZE_W + 2;
  localparam int STORE_DEPTH = HEAP_GRANULES + 1;

  localparam int ROUND_ADD  = HEADER_BYTES + GRANULE_BYTES - 1;
  localparam int NEED_MAX   = ((1 << REQ_W) - 1 + ROUND_ADD) / GRANULE_BYTES;
  localparam int NEED_BITS  = $clog2(NEED_MAX + 1);
  localparam int CMP_W      = (SIZE_W > NEED_BITS) ? SIZE_W : NEED_BITS;
  localparam int ALU_W      = (REQ_W + 1 > IDX_W + 1) ? REQ_W + 1 : IDX_W + 1;

  // header word layout
  localparam int BUSY_POS   = 0;
  localparam int PREV_POS   = 1;
  localparam int SIZE_SHIFT = 2;

  localparam logic [WORD_W-1:0] END_MARK  = WORD_W'(1);
  localparam logic [WORD_W-1:0] INIT_WORD = {SIZE_W'(HEAP_GRANULES), 1'b1, 1'b0};

  typedef enum logic [1:0] {
    ALU_ADD = 2'b01,
    ALU_SUB = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             zero;
  } alu_rsp_t;

endpackage

>>> sv/bfba_ram.sv
// generic single-port ram with registered read
module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= wdata;
    end
    rdata <= store[addr];
  end

endmodule

>>> sv/bfba_alu.sv
// shared adder / subtractor used by the idle, eval, alloc and split steps of the sequencer
module bfba_alu (
  input  bfba_pkg::alu_req_t req,
  output bfba_pkg::alu_rsp_t rsp
);
  import bfba_pkg::*;

  logic [ALU_W-1:0] result;

  always_comb begin
    unique case (req.op)
      ALU_ADD: result = req.a + req.b;
      ALU_SUB: result = req.a - req.b;
      default: result = '0;
    endcase
  end

  assign rsp.sum  = result;
  assign rsp.zero = (result == '0);

endmodule

>>> sv/best_fit_block_allocator_top.sv
// best-fit allocator: walks block headers in ram, reading each header in S_RD
// and evaluating it in S_EVAL; a zero request goes from idle straight to S_RESULT
// and strobes done ungranted; otherwise a miss passes S_FIN then S_RESULT, and a
// grant passes S_FIN, S_ALLOC, S_SPLIT (and S_NXT on an exact fit) then S_RESULT
// one request at a time, set by the single ram port and the shared adder
// reset: synchronous; S_INIT0/S_INIT1 write the heap header and end mark, busy high
module best_fit_block_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bfba_pkg::REQ_W-1:0] request_bytes,
  output logic                       busy,
  output logic                       done,
  output logic                       granted,
  output logic [bfba_pkg::OUT_W-1:0] payload_offset
);
  import bfba_pkg::*;

  typedef enum logic [9:0] {
    S_INIT0  = 10'b0000000001,
    S_INIT1  = 10'b0000000010,
    S_IDLE   = 10'b0000000100,
    S_RD     = 10'b0000001000,
    S_EVAL   = 10'b0000010000,
    S_FIN    = 10'b0000100000,
    S_ALLOC  = 10'b0001000000,
    S_SPLIT  = 10'b0010000000,
    S_NXT    = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]  idx;
  logic [CMP_W-1:0]  need;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [SIZE_W-1:0] best_size;
  logic              best_prev;
  logic [SIZE_W-1:0] rem;
  logic              rem_zero;
  logic [IDX_W-1:0]  nxt;
  logic              grant_r;
  logic [OUT_W-1:0]  off_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [SIZE_W-1:0] sz;
  logic              is_end;
  logic              fit;
  logic              better;
  logic              exact;
  logic              last;
  logic [IDX_W+GRAN_SHIFT-1:0] off_full;

  bfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bfba_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // header decode of the beat read back from the store
  assign sz     = ram_rdata[WORD_W-1:SIZE_SHIFT];
  assign is_end = (ram_rdata == END_MARK) || (sz == '0) ||
                  (alu_rsp.sum > ALU_W'(HEAP_GRANULES));
  assign fit    = !ram_rdata[BUSY_POS] && (CMP_W'(sz) >= need);
  assign better = fit && (!found || (sz < best_size));
  assign exact  = fit && (CMP_W'(sz) == need);
  assign last   = alu_rsp.sum >= ALU_W'(HEAP_GRANULES);

  assign off_full = {best_idx, {GRAN_SHIFT{1'b0}}};

  // shared adder operand selection
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_IDLE: begin
        alu_req.a = ALU_W'(request_bytes);
        alu_req.b = ALU_W'(ROUND_ADD);
      end
      S_EVAL: begin
        alu_req.a = ALU_W'(idx);
        alu_req.b = ALU_W'(sz);
      end
      S_ALLOC: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(best_size);
        alu_req.b  = ALU_W'(need);
      end
      S_SPLIT: begin
        alu_req.a = ALU_W'(best_idx);
        alu_req.b = rem_zero ? ALU_W'(best_size) : ALU_W'(need);
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  // store port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = ram_rdata | WORD_W'(1 << PREV_POS);
    unique case (state)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = INIT_WORD;
      end
      S_INIT1: begin
        ram_we    = 1'b1;
        ram_addr  = IDX_W'(HEAP_GRANULES);
        ram_wdata = END_MARK;
      end
      S_ALLOC: begin
        ram_we    = 1'b1;
        ram_addr  = best_idx;
        ram_wdata = {SIZE_W'(need), best_prev, 1'b1};
      end
      S_SPLIT: begin
        // split writes the remainder header, exact fit reads the next header
        ram_we    = !rem_zero;
        ram_addr  = IDX_W'(alu_rsp.sum);
        ram_wdata = {rem, 1'b1, 1'b0};
      end
      S_NXT: begin
        ram_we    = (ram_rdata != END_MARK);
        ram_addr  = nxt;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT0:  state_next = S_INIT1;
      S_INIT1:  state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_next = (request_bytes == '0) ? S_RESULT : S_RD;
        end
      end
      S_RD:     state_next = S_EVAL;
      S_EVAL: begin
        if (is_end || exact || last) begin
          state_next = S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_FIN:    state_next = found ? S_ALLOC : S_RESULT;
      S_ALLOC:  state_next = S_SPLIT;
      S_SPLIT:  state_next = rem_zero ? S_NXT : S_RESULT;
      S_NXT:    state_next = S_RESULT;
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx     <= '0;
        found   <= 1'b0;
        need    <= CMP_W'(alu_rsp.sum >> GRAN_SHIFT);
        grant_r <= 1'b0;
        off_r   <= '0;
      end
      S_EVAL: begin
        if (!is_end) begin
          idx <= IDX_W'(alu_rsp.sum);
          if (better) begin
            found     <= 1'b1;
            best_idx  <= idx;
            best_size <= sz;
            best_prev <= ram_rdata[PREV_POS];
          end
        end
      end
      S_ALLOC: begin
        rem      <= SIZE_W'(alu_rsp.sum);
        rem_zero <= alu_rsp.zero;
        grant_r  <= 1'b1;
        off_r    <= OUT_W'(off_full) | OUT_W'(HEADER_BYTES);
      end
      S_SPLIT: begin
        nxt <= IDX_W'(alu_rsp.sum);
      end
      default: begin
        nxt <= nxt;
      end
    endcase
  end

  assign busy           = (state != S_IDLE);
  assign done           = (state == S_RESULT);
  assign granted        = grant_r;
  assign payload_offset = off_r;

endmodule

>>> sv/bfba_checker.sv
// port-level checks on the allocator, bound to the top level
`include "best_fit_block_allocator_top_macros.svh"

module bfba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic [bfba_pkg::REQ_W-1:0] request_bytes,
  input logic                       busy,
  input logic                       done,
  input logic                       granted,
  input logic [bfba_pkg::OUT_W-1:0] payload_offset
);
  import bfba_pkg::*;

  logic zero_accept;

  assign zero_accept = start && !busy && (request_bytes == '0);

  `BFBA_ASSERT_NEXT(a_done_single, done, !done, "done strobe held for more than one cycle")
  `BFBA_ASSERT_NOW(a_done_busy, done, busy, "result beat shown while idle")
  `BFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `BFBA_ASSERT_NOW(a_miss_zero, done && !granted, payload_offset == '0, "refused beat has offset")
  `BFBA_ASSERT_NEXT(a_zero_req, zero_accept, done && !granted, "zero request not refused")

endmodule

bind best_fit_block_allocator_top bfba_checker u_chk (.*);
